// File: rtl/core/bda_pkg.sv
// Shared types, constants and event mapping for the button debounce block.
package bda_pkg;

  // Number of buttons and the width of a button index
  localparam int BUTTON_COUNT = 3;
  localparam int BtnW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

  // Menu event codes
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_NEXT   = 2'd1;
  localparam logic [1:0] EV_PREV   = 2'd2;
  localparam logic [1:0] EV_SELECT = 2'd3;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_DEBOUNCE   = 3'd0;
  localparam logic [2:0] REG_INIT_REP   = 3'd1;
  localparam logic [2:0] REG_MIN_REP    = 3'd2;
  localparam logic [2:0] REG_ACCEL      = 3'd3;
  localparam logic [2:0] REG_SLEEP      = 3'd4;
  localparam logic [2:0] REG_SWAP       = 3'd5;

  // Reset values of the registers
  localparam logic [15:0] DEBOUNCE_RST = 16'd20;
  localparam logic [15:0] INIT_REP_RST = 16'd500;
  localparam logic [15:0] MIN_REP_RST  = 16'd50;
  localparam logic [3:0]  ACCEL_RST    = 4'd3;
  localparam logic [31:0] SLEEP_RST    = 32'd60000;

  typedef logic [BUTTON_COUNT-1:0] levels_t;

  typedef struct packed {
    logic [15:0] debounce_ticks;
    logic [15:0] initial_repeat_ticks;
    logic [15:0] min_repeat_ticks;
    logic [3:0]  accel_shift;
    logic [31:0] idle_limit;
    logic        nav_swap;
  } cfg_t;

  // Map a button to its menu event
  function automatic logic [1:0] event_of(input logic [BtnW-1:0] button, input logic swap);
    logic [1:0] ev;
    if (button == BtnW'(0)) begin
      ev = swap ? EV_PREV : EV_NEXT;
    end else if (button == BtnW'(1)) begin
      ev = swap ? EV_NEXT : EV_PREV;
    end else begin
      ev = EV_SELECT;
    end
    return ev;
  endfunction

endpackage

// File: rtl/core/bda_engine.sv
// Per-tick state update: edge detect, debounce, auto-repeat and idle blanking.
module bda_engine
  import bda_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  levels_t    levels,
  input  cfg_t       cfg,
  output logic [1:0] menu_event,
  output logic       screen_blank
);

  levels_t          prev_levels, prev_levels_next;
  logic [BtnW-1:0]  chosen, chosen_next;
  logic             deb_run, deb_run_next;
  logic [15:0]      deb_left, deb_left_next;
  logic             rep_run, rep_run_next;
  logic [15:0]      rep_left, rep_left_next;
  logic [15:0]      rep_period, rep_period_next;
  logic [31:0]      idle_count, idle_count_next;
  logic             asleep, asleep_next;

  levels_t          changed;
  logic             fired;
  logic [1:0]       ev_raw;
  logic [1:0]       ev_out;
  logic [15:0]      shrunk;

  assign changed = levels ^ prev_levels;
  assign shrunk  = rep_period - (rep_period >> cfg.accel_shift);

  // Work out the next state and the event of this tick
  always_comb begin
    prev_levels_next = levels;
    chosen_next      = chosen;
    deb_run_next     = deb_run;
    deb_left_next    = deb_left;
    rep_run_next     = rep_run;
    rep_left_next    = rep_left;
    rep_period_next  = rep_period;
    idle_count_next  = idle_count;
    asleep_next      = asleep;
    fired            = 1'b0;
    ev_raw           = EV_NONE;

    // Restart the debounce on any edge; the highest changed button wins
    if (changed != '0) begin
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        if (changed[i]) begin
          chosen_next = BtnW'(i);
        end
      end
      deb_run_next  = 1'b1;
      deb_left_next = cfg.debounce_ticks;
    end else if (deb_run) begin
      if (deb_left <= 16'd1) begin
        deb_left_next = '0;
        deb_run_next  = 1'b0;
        fired         = 1'b1;
        if (!levels[chosen]) begin
          ev_raw = event_of(chosen, cfg.nav_swap);
          if (ev_raw != EV_SELECT) begin
            rep_period_next = cfg.initial_repeat_ticks;
            rep_left_next   = cfg.initial_repeat_ticks;
            rep_run_next    = 1'b1;
          end
        end else begin
          rep_run_next = 1'b0;
        end
      end else begin
        deb_left_next = deb_left - 16'd1;
      end
    end

    // Advance the auto-repeat unless the debounce fired this tick
    if (!fired && rep_run) begin
      if (rep_left <= 16'd1) begin
        rep_period_next = (shrunk < cfg.min_repeat_ticks) ? cfg.min_repeat_ticks : shrunk;
        rep_left_next   = rep_period_next;
        ev_raw          = event_of(chosen_next, cfg.nav_swap);
      end else begin
        rep_left_next = rep_left - 16'd1;
      end
    end

    // Track idle time; swallow the first event while blanked
    ev_out = ev_raw;
    if (ev_raw != EV_NONE) begin
      idle_count_next = '0;
      if (asleep) begin
        asleep_next = 1'b0;
        ev_out      = EV_NONE;
      end
    end else begin
      if (idle_count != '1) begin
        idle_count_next = idle_count + 32'd1;
      end
      if (!asleep && cfg.idle_limit != '0 && idle_count_next > cfg.idle_limit) begin
        asleep_next = 1'b1;
      end
    end
  end

  assign menu_event   = ev_out;
  assign screen_blank = asleep_next;

  // Hold state between words, update once per accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_levels <= '1;
      chosen      <= '0;
      deb_run     <= 1'b0;
      deb_left    <= '0;
      rep_run     <= 1'b0;
      rep_left    <= '0;
      rep_period  <= '0;
      idle_count  <= '0;
      asleep      <= 1'b0;
    end else if (step) begin
      prev_levels <= prev_levels_next;
      chosen      <= chosen_next;
      deb_run     <= deb_run_next;
      deb_left    <= deb_left_next;
      rep_run     <= rep_run_next;
      rep_left    <= rep_left_next;
      rep_period  <= rep_period_next;
      idle_count  <= idle_count_next;
      asleep      <= asleep_next;
    end
  end

`ifndef NO_ASSERTIONS
  // Debounce ends only after its countdown has run out
  a_deb_end: assert property (@(posedge clk) disable iff (rst)
    $fell(deb_run) |-> $past(deb_left) <= 16'd1)
    else $error("debounce stopped early");

  // A tick with a raw event clears the idle counter
  a_idle_clr: assert property (@(posedge clk) disable iff (rst)
    step && ev_raw != EV_NONE |=> idle_count == '0)
    else $error("idle counter not cleared by event");

  // Blanking starts only with blanking enabled
  a_sleep_en: assert property (@(posedge clk) disable iff (rst)
    $rose(asleep) |-> $past(cfg.idle_limit) != '0)
    else $error("blanked with blanking disabled");

  // The waking event never reaches the output
  a_wake: assert property (@(posedge clk) disable iff (rst)
    step && asleep |-> menu_event == EV_NONE || !asleep_next)
    else $error("event passed while blanked");
`endif

endmodule

// File: rtl/core/button_debounce_autorepeat_idle.sv
// Top level: configuration registers, input and result registers around the tick engine.
// Each input word is one timer tick carrying the raw active-low button levels; each
// accepted word gives exactly one result word (menu event and screen blank flag). A word
// can be accepted every cycle while the result register is not stalled; the word sits in
// the input register, then the edge that moves it on loads the result register. The whole
// per-tick update (debounce and repeat countdowns, repeat acceleration, idle counter)
// is a single pass of logic between those two registers. The result register stalls
// on out_ready and the input register fills behind it. Configuration registers sit on
// an APB port at byte addresses 4*i and should be written only while the block is idle.
module button_debounce_autorepeat_idle
  import bda_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // tick input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  button_levels,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  menu_event,
  output logic        screen_blank
);

  cfg_t        cfg;
  logic [2:0]  reg_idx;
  logic        cfg_wr;
  logic        lvl_valid;
  levels_t     lvl;
  logic        advance;
  logic [1:0]  eng_event;
  logic        eng_blank;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks       <= DEBOUNCE_RST;
      cfg.initial_repeat_ticks <= INIT_REP_RST;
      cfg.min_repeat_ticks     <= MIN_REP_RST;
      cfg.accel_shift          <= ACCEL_RST;
      cfg.idle_limit           <= SLEEP_RST;
      cfg.nav_swap             <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DEBOUNCE: cfg.debounce_ticks       <= pwdata[15:0];
        REG_INIT_REP: cfg.initial_repeat_ticks <= pwdata[15:0];
        REG_MIN_REP:  cfg.min_repeat_ticks     <= pwdata[15:0];
        REG_ACCEL:    cfg.accel_shift          <= pwdata[3:0];
        REG_SLEEP:    cfg.idle_limit           <= pwdata;
        REG_SWAP:     cfg.nav_swap             <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    case (reg_idx)
      REG_DEBOUNCE: prdata = {16'd0, cfg.debounce_ticks};
      REG_INIT_REP: prdata = {16'd0, cfg.initial_repeat_ticks};
      REG_MIN_REP:  prdata = {16'd0, cfg.min_repeat_ticks};
      REG_ACCEL:    prdata = {28'd0, cfg.accel_shift};
      REG_SLEEP:    prdata = cfg.idle_limit;
      REG_SWAP:     prdata = {31'd0, cfg.nav_swap};
      default:      prdata = '0;
    endcase
  end

  // Move a word from the input register to the result register when there is room
  assign advance  = lvl_valid && (!out_valid || out_ready);
  assign in_ready = !lvl_valid || advance;

  // Capture the incoming word
  always_ff @(posedge clk) begin
    if (rst) begin
      lvl_valid <= 1'b0;
    end else if (in_ready) begin
      lvl_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      lvl <= button_levels[BUTTON_COUNT-1:0];
    end
  end

  bda_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .levels       (lvl),
    .cfg          (cfg),
    .menu_event   (eng_event),
    .screen_blank (eng_blank)
  );

  // Hold the result word until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      menu_event   <= eng_event;
      screen_blank <= eng_blank;
    end
  end

endmodule
